>>> rtl/core/tls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants of the two-list time-slice scheduler: item
// layouts, the control state machine states and the list shift controls.
// ----------------------------------------------------------------------------
package tls_pkg;

   // default sizes
   localparam int MAX_TASKS_DEF     = 64;
   localparam int PRIORITY_BITS_DEF = 8;

   // fixed field widths
   localparam int TASK_ID_W       = 6;
   localparam int TASK_PRIORITY_W = 8;

   // action codes
   typedef enum logic {
      ACT_YIELD = 1'b0,
      ACT_ADD   = 1'b1
   } action_type;

   // input item
   typedef struct packed {
      logic                       action;
      logic [TASK_ID_W-1:0]       task_id;
      logic [TASK_PRIORITY_W-1:0] task_priority;
      logic                       list_select;
      logic                       current_runnable;
   } req_type;

   // result item
   typedef struct packed {
      logic                 run_valid;
      logic [TASK_ID_W-1:0] run_task;
      logic                 no_task;
      logic                 add_rejected;
   } rsp_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP
   } state_type;

   // shift controls for one list
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage : tls_pkg
`default_nettype wire

>>> rtl/core/tls_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_cell
// One entry of a task list: loads its upper neighbor on a push and its lower
// neighbor on a pop, holds otherwise.
// ----------------------------------------------------------------------------
module tls_cell
   import tls_pkg::*;
#(
   parameter int ENTRY_W = TASK_ID_W + PRIORITY_BITS_DEF
) (
   input  wire logic               clock,
   input  wire stack_ctl_type      ctl,
   input  wire logic [ENTRY_W-1:0] from_prev,
   input  wire logic [ENTRY_W-1:0] from_next,
   output logic      [ENTRY_W-1:0] entry_q
);

   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] entry_in;

   // shift toward the tail on push, toward the head on pop
   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         entry_in = from_prev;
      end else if (ctl.pop) begin
         entry_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule : tls_cell
`default_nettype wire

>>> rtl/core/tls_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_stack
// Last-in-first-out task list built as a chain of shifting cells with the
// head in the first cell, plus a fill count.
// ----------------------------------------------------------------------------
module tls_stack
   import tls_pkg::*;
#(
   parameter int DEPTH   = MAX_TASKS_DEF,
   parameter int ENTRY_W = TASK_ID_W + PRIORITY_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stack_ctl_type      ctl,
   input  wire logic [ENTRY_W-1:0] push_entry,
   output logic      [ENTRY_W-1:0] head,
   output logic                    full,
   output logic                    empty
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [ENTRY_W-1:0] cell_q [DEPTH];

   // fill count
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = cell_q[0];

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_W-1:0] prev_d;
      logic [ENTRY_W-1:0] next_d;

      if (i == 0) begin : g_first
         assign prev_d = push_entry;
      end else begin : g_mid_prev
         assign prev_d = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_d = cell_q[i];
      end else begin : g_mid_next
         assign next_d = cell_q[i+1];
      end

      tls_cell #(
         .ENTRY_W (ENTRY_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .from_prev (prev_d),
         .from_next (next_d),
         .entry_q   (cell_q[i])
      );
   end

endmodule : tls_stack
`default_nettype wire

>>> rtl/core/two_list_time_slice_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_list_time_slice_scheduler
// Task dispatcher with two LIFO task lists held in shifting cell chains, an
// active-list bit and the current task with its remaining slice.
// ----------------------------------------------------------------------------
// Sequence: an add or a reissued yield is captured in ST_IDLE and loads the
// result register from ST_EXEC; a yield that dispatches from a list re-queues
// into one list in ST_EXEC, then flips and pops in ST_POP.
// Throughput: the sequencer works on one item at a time; the result register
// lets the next item in early.
// Reset: counts, active bit, current task and slice clear; list cells are
// not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module two_list_time_slice_scheduler
   import tls_pkg::*;
#(
   parameter int MAX_TASKS     = MAX_TASKS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int PW      = PRIORITY_BITS;
   localparam int ENTRY_W = TASK_ID_W + PW;

   state_type            state_ff, state_in;
   req_type              item_ff, item_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 active_ff, active_in;
   logic [TASK_ID_W-1:0] cur_task_ff, cur_task_in;
   logic [PW-1:0]        cur_prio_ff, cur_prio_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [PW-1:0]        slice_ff, slice_in;

   stack_ctl_type        ctl0, ctl1;
   logic [ENTRY_W-1:0]   push_d, head0, head1, head_sel;
   logic                 full0, full1, empty0, empty1;
   logic [PW-1:0]        add_prio, dec_slice;
   logic                 out_free, reissue, requeue, pick, pick_empty, tgt_full;

   // keep the low priority bits of an added task, zero-extended if PW is wider
   if (PW <= TASK_PRIORITY_W) begin : g_prio_trunc
      assign add_prio = item_ff.task_priority[PW-1:0];
   end else begin : g_prio_ext
      assign add_prio = {{(PW - TASK_PRIORITY_W){1'b0}}, item_ff.task_priority};
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dec_slice = (slice_ff != '0) ? (slice_ff - 1'b1) : '0;
   assign reissue   = (dec_slice != '0) && cur_valid_ff && item_ff.current_runnable;
   assign requeue   = cur_valid_ff && item_ff.current_runnable;

   // list chosen for the pop: flip when the active one is empty
   assign pick       = (active_ff ? empty1 : empty0) ? !active_ff : active_ff;
   assign pick_empty = pick ? empty1 : empty0;
   assign head_sel   = pick ? head1 : head0;

   // sequencer, next state and list controls
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      active_in    = active_ff;
      cur_task_in  = cur_task_ff;
      cur_prio_in  = cur_prio_ff;
      cur_valid_in = cur_valid_ff;
      slice_in     = slice_ff;
      ctl0         = '0;
      ctl1         = '0;
      push_d       = {cur_task_ff, cur_prio_ff};
      tgt_full     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_ff.action == ACT_ADD) begin
               // push onto the chosen list unless full
               tgt_full = item_ff.list_select ? full1 : full0;
               push_d   = {item_ff.task_id, add_prio};
               if (out_free) begin
                  ctl0.push    = !item_ff.list_select && !full0;
                  ctl1.push    = item_ff.list_select && !full1;
                  rsp_in       = '0;
                  rsp_in.add_rejected = tgt_full;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (reissue) begin
               // slice remains: run the current task again
               if (out_free) begin
                  slice_in         = dec_slice;
                  rsp_in           = '0;
                  rsp_in.run_valid = 1'b1;
                  rsp_in.run_task  = cur_task_ff;
                  rsp_valid_in     = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               // re-queue a runnable task onto the inactive list
               if (requeue) begin
                  ctl0.push = active_ff && !full0;
                  ctl1.push = !active_ff && !full1;
               end
               slice_in     = dec_slice;
               cur_valid_in = 1'b0;
               state_in     = ST_POP;
            end
         end
         ST_POP: begin
            if (out_free) begin
               active_in    = pick;
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (!pick_empty) begin
                  ctl0.pop         = !pick;
                  ctl1.pop         = pick;
                  cur_task_in      = head_sel[ENTRY_W-1 -: TASK_ID_W];
                  cur_prio_in      = head_sel[PW-1:0];
                  cur_valid_in     = 1'b1;
                  slice_in         = head_sel[PW-1:0];
                  rsp_in.run_valid = 1'b1;
                  rsp_in.run_task  = head_sel[ENTRY_W-1 -: TASK_ID_W];
               end else begin
                  slice_in       = '0;
                  rsp_in.no_task = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         cur_task_ff  <= '0;
         cur_prio_ff  <= '0;
         cur_valid_ff <= 1'b0;
         slice_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         cur_task_ff  <= cur_task_in;
         cur_prio_ff  <= cur_prio_in;
         cur_valid_ff <= cur_valid_in;
         slice_ff     <= slice_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // the two task lists
   tls_stack #(
      .DEPTH   (MAX_TASKS),
      .ENTRY_W (ENTRY_W)
   ) u_list0 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl0),
      .push_entry (push_d),
      .head       (head0),
      .full       (full0),
      .empty      (empty0)
   );

   tls_stack #(
      .DEPTH   (MAX_TASKS),
      .ENTRY_W (ENTRY_W)
   ) u_list1 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl1),
      .push_entry (push_d),
      .head       (head1),
      .full       (full1),
      .empty      (empty1)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : two_list_time_slice_scheduler
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-list time-slice scheduler. A mirror of the
// dispatcher state predicts one result per accepted item. Stimulus is a
// directed opening, random add and yield traffic with a long result hold-off,
// list fill and drain runs, then random traffic under changing handshake gaps.
// ----------------------------------------------------------------------------
module testbench;
   import tls_pkg::*;

   // one stored list entry
   typedef struct packed {
      logic [TASK_ID_W-1:0]       id;
      logic [TASK_PRIORITY_W-1:0] prio;
   } task_slot_type;

   // mirror of the dispatcher state, holds the dispatches still due
   class task_list_mirror;
      task_slot_type lists [2][MAX_TASKS_DEF];
      int unsigned   fill [2];
      bit            active_sel;
      task_slot_type current;
      bit            current_valid;
      logic [TASK_PRIORITY_W-1:0] slice_left;
      rsp_type       dispatches_due [$];
      int            errors;

      function new();
         fill[0] = 0;
         fill[1] = 0;
         active_sel = 1'b0;
         current = '0;
         current_valid = 1'b0;
         slice_left = '0;
         errors = 0;
      endfunction

      function bit push_task(bit which, task_slot_type slot);
         if (fill[which] >= MAX_TASKS_DEF) return 1'b0;
         lists[which][fill[which]] = slot;
         fill[which]++;
         return 1'b1;
      endfunction

      function int pending();
         return dispatches_due.size();
      endfunction

      // work out the result of one accepted item
      function void note_item(req_type item);
         rsp_type       due;
         task_slot_type slot;
         due = '0;
         slot.id = item.task_id;
         slot.prio = item.task_priority;
         if (item.action == ACT_ADD) begin
            if (!push_task(item.list_select, slot)) due.add_rejected = 1'b1;
         end else begin
            slice_left = (slice_left != 0) ? slice_left - 1'b1 : '0;
            if (slice_left != 0 && current_valid && item.current_runnable) begin
               due.run_valid = 1'b1;
               due.run_task = current.id;
            end else begin
               // re-queue onto the inactive list, dropped if that list is full
               if (current_valid && item.current_runnable)
                  void'(push_task(!active_sel, current));
               current_valid = 1'b0;
               if (fill[active_sel] == 0) active_sel = !active_sel;
               if (fill[active_sel] > 0) begin
                  fill[active_sel]--;
                  current = lists[active_sel][fill[active_sel]];
                  current_valid = 1'b1;
                  slice_left = current.prio;
                  due.run_valid = 1'b1;
                  due.run_task = current.id;
               end else begin
                  slice_left = '0;
                  due.no_task = 1'b1;
               end
            end
         end
         dispatches_due.push_back(due);
      endfunction

      // compare one accepted result with the oldest dispatch due
      function void check_result(rsp_type got);
         rsp_type due;
         if (dispatches_due.size() == 0) begin
            $error("unexpected result item %h", got);
            errors++;
            return;
         end
         due = dispatches_due.pop_front();
         if (got.run_valid !== due.run_valid) begin
            $error("run_valid: expected %0d, got %0d", due.run_valid, got.run_valid);
            errors++;
         end
         if (got.run_task !== due.run_task) begin
            $error("run_task: expected %0d, got %0d", due.run_task, got.run_task);
            errors++;
         end
         if (got.no_task !== due.no_task) begin
            $error("no_task: expected %0d, got %0d", due.no_task, got.no_task);
            errors++;
         end
         if (got.add_rejected !== due.add_rejected) begin
            $error("add_rejected: expected %0d, got %0d", due.add_rejected,
                   got.add_rejected);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   task_list_mirror mirror;
   int send_gap_pct;
   int recv_gap_pct;
   int hold_left;

   two_list_time_slice_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // result side: check accepted items, then pick the next stall
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) mirror.check_result(rsp_data);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_gap_pct);
         end
      end
   end

   function automatic req_type add_item(bit sel, int id, int prio);
      req_type item;
      item = '0;
      item.action = ACT_ADD;
      item.task_id = TASK_ID_W'(id);
      item.task_priority = TASK_PRIORITY_W'(prio);
      item.list_select = sel;
      item.current_runnable = 1'($urandom_range(1));
      return item;
   endfunction

   function automatic req_type yield_item(bit runnable);
      req_type item;
      item = '0;
      item.action = ACT_YIELD;
      item.task_id = TASK_ID_W'($urandom_range(63));
      item.task_priority = TASK_PRIORITY_W'($urandom_range(255));
      item.list_select = 1'($urandom_range(1));
      item.current_runnable = runnable;
      return item;
   endfunction

   // random item, mostly short slices so that lists keep turning over
   function automatic req_type random_item(int add_pct, int run_pct);
      req_type item;
      int      prio;
      prio = ($urandom_range(9) < 7) ? $urandom_range(4) : $urandom_range(255);
      if ($urandom_range(99) < add_pct)
         item = add_item(1'($urandom_range(1)), $urandom_range(63), prio);
      else
         item = yield_item($urandom_range(99) < run_pct);
      return item;
   endfunction

   // offer one item, with a random gap in front of it
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      mirror.note_item(item);
   endtask

   // stop offering and wait for every result due
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      mirror = new();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      hold_left = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty yields, extreme ids and priorities, slice expiry, drop
      send_item(yield_item(1'b1));
      send_item(yield_item(1'b0));
      send_item(add_item(1'b1, 63, 255));
      send_item(add_item(1'b0, 0, 0));
      send_item(add_item(1'b0, 42, 1));
      send_item(add_item(1'b1, 21, 2));
      send_item(add_item(1'b0, 5, 128));
      repeat (6) send_item(yield_item(1'b1));
      send_item(yield_item(1'b0));
      repeat (4) send_item(yield_item(1'b1));
      repeat (4) send_item(yield_item(1'b0));

      // sender 23, receiver 58; first a long hold-off so the block backs up
      send_gap_pct = 23;
      recv_gap_pct = 58;
      hold_left = 200;
      repeat (20) send_item(random_item(40, 75));
      wait_drained();
      repeat (400) send_item(random_item(30, 75));

      // full lists: rejected adds, then re-queue onto a full list
      for (int i = 0; i < 66; i++)
         send_item(add_item(1'b0, $urandom_range(63), $urandom_range(3)));
      for (int i = 0; i < 66; i++)
         send_item(add_item(1'b1, $urandom_range(63), $urandom_range(3)));
      repeat (30) send_item(yield_item(1'b1));
      // drain both lists down to no task
      repeat (135) send_item(yield_item(1'b0));

      // the other way round
      send_gap_pct = 58;
      recv_gap_pct = 23;
      repeat (450) send_item(random_item(30, 70));

      // no gaps on either side
      send_gap_pct = 0;
      recv_gap_pct = 0;
      repeat (450) send_item(random_item(30, 70));

      wait_drained();
      repeat (10) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
